// ===== src/wsdr_pkg.sv =====
package wsdr_pkg;

  localparam int HALF_TAPS      = 8;
  localparam int TAPS           = 2 * HALF_TAPS;
  localparam int HISTORY_FRAMES = 16;
  localparam int PHASE_COUNT    = 64;
  localparam int STORE_FRAMES   = 64;
  localparam int PRIME_COPIES   = (HISTORY_FRAMES + 1 <= STORE_FRAMES) ?
                                  HISTORY_FRAMES : (STORE_FRAMES - 1);
  localparam int CHANNELS       = 6;
  localparam int SAMPLE_W       = 16;
  localparam int W_W            = 18;
  localparam int ACC_W          = 40;
  localparam int ADDR_W         = $clog2(STORE_FRAMES);
  localparam int COUNT_W        = $clog2(STORE_FRAMES + 1);
  localparam int PHASE_W        = $clog2(PHASE_COUNT);
  localparam int TAP_W          = $clog2(TAPS);
  localparam int FRAC_W         = 32;
  localparam int POS_INT_W      = 8;
  localparam int POS_W          = FRAC_W + POS_INT_W;
  localparam int OFFSET_W       = 24;
  localparam int LEVEL_W        = 7;
  localparam int CFG_IDX_W      = 1;
  localparam int FRAME_W        = CHANNELS * SAMPLE_W;

  localparam logic [CFG_IDX_W-1:0] REG_SURROUND = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET   = 1'd1;

  localparam logic REQ_PUSH    = 1'b0;
  localparam logic REQ_RESTART = 1'b1;

  localparam longint OFFSET_LIMIT = 64'sd4294967;
  localparam longint Q30_ONE      = 64'sd1073741824;
  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam longint W_ONE        = 64'sd65536;

  typedef logic [CHANNELS-1:0][SAMPLE_W-1:0] frame_t;
  typedef logic [TAPS-1:0][W_W-1:0]          wrow_t;
  typedef wrow_t [PHASE_COUNT-1:0]           wtab_t;
  typedef logic signed [ACC_W-1:0]           acc_t;

  typedef struct packed {
    logic clr;
    logic en;
  } lane_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRIME,
    ST_CHECK,
    ST_MAC,
    ST_DRAIN,
    ST_ROUND,
    ST_COMPACT,
    ST_FINISH
  } state_e;

  // Shift-and-subtract long division; only evaluated while the weight table is built.
  function automatic longint unsigned udiv(longint unsigned n, longint unsigned d);
    longint unsigned q, r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r    = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Signed division that truncates toward zero.
  function automatic longint sdiv(longint n, longint d);
    longint unsigned q;
    q = udiv(longint'(n < 0 ? -n : n), longint'(d < 0 ? -d : d));
    return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
  endfunction

  // Sine of pi*num/den in Q30; den is the phase count, or that times the half width.
  function automatic longint sin_pi(longint num, bit wide);
    bit neg;
    longint unsigned a, ud, x, x2, term;
    neg  = num < 0;
    a    = neg ? longint'(-num) : longint'(num);
    ud   = wide ? longint'(PHASE_COUNT * HALF_TAPS) : longint'(PHASE_COUNT);
    a    = wide ? a % (2 * PHASE_COUNT * HALF_TAPS) : a % (2 * PHASE_COUNT);
    if (a >= ud) begin
      a   = a - ud;
      neg = !neg;
    end
    if (2 * a > ud) a = ud - a;
    x    = wide ? (a * PI_Q30) / (PHASE_COUNT * HALF_TAPS) : (a * PI_Q30) / PHASE_COUNT;
    x2   = (x * x) >> 30;
    term = Q30_ONE;
    for (int k = 8; k >= 1; k--) begin
      term = Q30_ONE - udiv((x2 * term) >> 30, longint'((2 * k) * (2 * k + 1)));
    end
    x = (x * term) >> 30;
    return neg ? -longint'(x) : longint'(x);
  endfunction

  function automatic longint sinc_q30(longint num, bit wide);
    longint s, pix;
    longint unsigned mag;
    if (num == 0) return Q30_ONE;
    s   = sin_pi(num, wide);
    mag = num < 0 ? longint'(-num) : longint'(num);
    pix = wide ? longint'((mag * PI_Q30) / (PHASE_COUNT * HALF_TAPS))
               : longint'((mag * PI_Q30) / PHASE_COUNT);
    if (pix == 0) return Q30_ONE;
    if (num < 0) pix = -pix;
    return sdiv(s * Q30_ONE, pix);
  endfunction

  // Lanczos weights in Q16; each row's residue goes to its largest tap.
  function automatic wtab_t build_wtab();
    wtab_t  t;
    longint raw [TAPS];
    longint w   [TAPS];
    longint total, sum, num, mag;
    int     best;
    for (int p = 0; p < PHASE_COUNT; p++) begin
      total = 0;
      sum   = 0;
      best  = 0;
      for (int k = 0; k < TAPS; k++) begin
        num = longint'(k - HALF_TAPS + 1) * PHASE_COUNT - p;
        mag = num < 0 ? -num : num;
        if (mag >= longint'(HALF_TAPS * PHASE_COUNT)) raw[k] = 0;
        else raw[k] = (sinc_q30(num, 1'b0) * sinc_q30(num, 1'b1)) / Q30_ONE;
        total = total + raw[k];
      end
      if (total <= 0) total = Q30_ONE;
      for (int k = 0; k < TAPS; k++) begin
        if (raw[k] >= 0) w[k] = sdiv(raw[k] * W_ONE + total / 2, total);
        else w[k] = -sdiv(-raw[k] * W_ONE + total / 2, total);
        sum = sum + w[k];
        if (w[k] > w[best]) best = k;
      end
      w[best] = w[best] + (W_ONE - sum);
      for (int k = 0; k < TAPS; k++) begin
        t[p][k] = W_W'(w[k]);
      end
    end
    return t;
  endfunction

  localparam wtab_t WTAB = build_wtab();

endpackage

// ===== src/wsdr_if.sv =====
interface wsdr_in_if import wsdr_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic signed [SAMPLE_W-1:0] in_ch0;
  logic signed [SAMPLE_W-1:0] in_ch1;
  logic signed [SAMPLE_W-1:0] in_ch2;
  logic signed [SAMPLE_W-1:0] in_ch3;
  logic signed [SAMPLE_W-1:0] in_ch4;
  logic signed [SAMPLE_W-1:0] in_ch5;

  modport source (output valid, req_type, in_ch0, in_ch1, in_ch2, in_ch3, in_ch4, in_ch5,
                  input ready);
  modport sink (input valid, req_type, in_ch0, in_ch1, in_ch2, in_ch3, in_ch4, in_ch5,
                output ready);
endinterface

interface wsdr_out_if import wsdr_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] out_ch0;
  logic signed [SAMPLE_W-1:0] out_ch1;
  logic signed [SAMPLE_W-1:0] out_ch2;
  logic signed [SAMPLE_W-1:0] out_ch3;
  logic signed [SAMPLE_W-1:0] out_ch4;
  logic signed [SAMPLE_W-1:0] out_ch5;
  logic [LEVEL_W-1:0]         buffered_level;
  logic                       last_of_run;

  modport source (output valid, out_ch0, out_ch1, out_ch2, out_ch3, out_ch4, out_ch5,
                  buffered_level, last_of_run, input ready);
  modport sink (input valid, out_ch0, out_ch1, out_ch2, out_ch3, out_ch4, out_ch5,
                buffered_level, last_of_run, output ready);
endinterface

// ===== src/windowed_sinc_drift_resampler.sv =====
// A push emits at most two results; the first push after a restart also primes the
// history. Requests are taken only in the idle state, so a new push waits until the last
// one is through and its results are queued; while the output keeps up, the rate is set by
// the single read port of the history RAM, which feeds 16 taps per output frame to the
// six channel lanes.
// Reset: rst_ni is asynchronous and active low; it empties the stream state and the
// output queue. The history RAM is not cleared; it is always written before read.
module windowed_sinc_drift_resampler import wsdr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [OFFSET_W-1:0]  cfg_data_i,
  wsdr_in_if.sink              in_chan,
  wsdr_out_if.source           out_chan
);

  typedef struct packed {
    frame_t             ch;
    logic [LEVEL_W-1:0] level;
    logic               last;
  } out_item_t;

  // Configuration.
  logic                       surround_q;
  logic signed [OFFSET_W-1:0] offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      surround_q <= 1'b0;
      offset_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SURROUND: surround_q <= cfg_data_i[0];
        REG_OFFSET:   offset_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The drift ratio is one plus the offset, clamped to a thousandth either way.
  logic signed [POS_W-1:0] off_ext, off_clamped, ratio;
  assign off_ext = POS_W'(offset_q);
  always_comb begin
    off_clamped = off_ext;
    if (off_ext > POS_W'(OFFSET_LIMIT)) off_clamped = POS_W'(OFFSET_LIMIT);
    if (off_ext < -POS_W'(OFFSET_LIMIT)) off_clamped = -POS_W'(OFFSET_LIMIT);
    ratio = (POS_W'(1) <<< FRAC_W) + off_clamped;
  end

  // Stream state. The history lives in a ring; head_q marks logical frame zero,
  // so dropping old frames only moves the head.
  state_e               state_q, state_d;
  logic [ADDR_W-1:0]    head_q;
  logic [COUNT_W-1:0]   wc_q;
  logic [POS_W-1:0]     pos_q;
  logic                 primed_q;
  logic [COUNT_W-1:0]   prime_cnt_q;
  logic [TAP_W-1:0]     tap_q;
  logic [ADDR_W-1:0]    base_q;
  logic [1:0]           prod_q;
  wrow_t                row_q;
  logic signed [W_W-1:0] weight_q;
  logic                 mac_vld_q;
  frame_t               frame_q;
  out_item_t            res_q [2];
  out_item_t            oq_q  [2];
  logic [1:0]           oq_cnt_q;
  logic                 oq_rd_q;

  logic [POS_INT_W-1:0] ip;
  logic                 emit_ok;
  logic                 in_acc;
  logic [POS_INT_W-1:0] drop;
  logic [LEVEL_W-1:0]   level;

  assign ip      = pos_q[POS_W-1:FRAC_W];
  assign emit_ok = (prod_q < 2'd2) && (ip >= POS_INT_W'(TAPS - 1)) &&
                   (ip < POS_INT_W'(wc_q));
  assign in_acc  = in_chan.valid && in_chan.ready;

  always_comb begin
    drop = '0;
    if (ip > POS_INT_W'(HISTORY_FRAMES)) begin
      drop = ip - POS_INT_W'(HISTORY_FRAMES);
      if (drop > POS_INT_W'(wc_q)) drop = POS_INT_W'(wc_q);
    end
  end

  // Level after compaction; COMPACT has already applied the drop in FINISH.
  assign level = (POS_INT_W'(wc_q) > ip) ? LEVEL_W'(POS_INT_W'(wc_q) - ip) : '0;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && in_chan.req_type == REQ_PUSH) begin
          state_d = primed_q ? ST_CHECK : ST_PRIME;
        end
      end
      ST_PRIME: if (prime_cnt_q == COUNT_W'(PRIME_COPIES)) state_d = ST_CHECK;
      ST_CHECK: state_d = emit_ok ? ST_MAC : ST_COMPACT;
      ST_MAC:   if (tap_q == TAP_W'(TAPS - 1)) state_d = ST_DRAIN;
      ST_DRAIN: state_d = ST_ROUND;
      ST_ROUND: state_d = ST_CHECK;
      ST_COMPACT: state_d = ST_FINISH;
      ST_FINISH: if (prod_q == 2'd0 || oq_cnt_q == 2'd0) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Control outputs.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  frame_t            ram_wdata, ram_rdata;
  lane_ctrl_t        lane_ctrl;
  frame_t            in_frame;

  assign in_frame = {in_chan.in_ch5, in_chan.in_ch4, in_chan.in_ch3,
                     in_chan.in_ch2, in_chan.in_ch1, in_chan.in_ch0};

  always_comb begin
    ram_we        = 1'b0;
    ram_waddr     = head_q + wc_q[ADDR_W-1:0];
    ram_wdata     = in_frame;
    ram_raddr     = head_q + base_q + ADDR_W'(tap_q);
    lane_ctrl.clr = 1'b0;
    lane_ctrl.en  = mac_vld_q;
    unique case (state_q)
      ST_IDLE: begin
        ram_we = in_acc && in_chan.req_type == REQ_PUSH && primed_q &&
                 wc_q < COUNT_W'(STORE_FRAMES);
      end
      ST_PRIME: begin
        ram_we    = 1'b1;
        ram_waddr = head_q + prime_cnt_q[ADDR_W-1:0];
        ram_wdata = frame_q;
      end
      ST_CHECK: lane_ctrl.clr = emit_ok;
      default: ;
    endcase
  end

  wsdr_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (STORE_FRAMES)
  ) u_history (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // One lane per channel; all lanes share the weight of the current tap.
  acc_t   lane_acc [CHANNELS];
  frame_t merged;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    wsdr_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (lane_ctrl),
      .weight_i (weight_q),
      .sample_i ($signed(ram_rdata[c])),
      .acc_o    (lane_acc[c])
    );
  end

  wsdr_merge u_merge (
    .acc_i      (lane_acc),
    .surround_i (surround_q),
    .frame_o    (merged)
  );

  // Datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      wc_q        <= '0;
      pos_q       <= '0;
      primed_q    <= 1'b0;
      prime_cnt_q <= '0;
      tap_q       <= '0;
      prod_q      <= '0;
      mac_vld_q   <= 1'b0;
      oq_cnt_q    <= '0;
      oq_rd_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      mac_vld_q <= (state_q == ST_MAC);
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            prod_q <= '0;
            if (in_chan.req_type == REQ_RESTART) begin
              wc_q     <= '0;
              pos_q    <= '0;
              primed_q <= 1'b0;
            end else if (!primed_q) begin
              prime_cnt_q <= '0;
            end else if (wc_q < COUNT_W'(STORE_FRAMES)) begin
              wc_q <= wc_q + COUNT_W'(1);
            end
          end
        end
        ST_PRIME: begin
          prime_cnt_q <= prime_cnt_q + COUNT_W'(1);
          if (prime_cnt_q == COUNT_W'(PRIME_COPIES)) begin
            wc_q     <= COUNT_W'(PRIME_COPIES + 1);
            pos_q    <= POS_W'(PRIME_COPIES) << FRAC_W;
            primed_q <= 1'b1;
          end
        end
        ST_CHECK: begin
          tap_q <= '0;
        end
        ST_MAC: tap_q <= tap_q + TAP_W'(1);
        ST_ROUND: begin
          prod_q <= prod_q + 2'd1;
          pos_q  <= pos_q + ratio;
        end
        ST_COMPACT: begin
          head_q <= head_q + drop[ADDR_W-1:0];
          wc_q   <= wc_q - COUNT_W'(drop);
          pos_q  <= pos_q - (POS_W'(drop) << FRAC_W);
        end
        default: ;
      endcase

      // Output queue: loaded whole once empty, drained one result at a time.
      if (state_q == ST_FINISH && prod_q != 2'd0 && oq_cnt_q == 2'd0) begin
        oq_cnt_q <= prod_q;
        oq_rd_q  <= 1'b0;
      end else if (out_chan.valid && out_chan.ready) begin
        oq_cnt_q <= oq_cnt_q - 2'd1;
        oq_rd_q  <= ~oq_rd_q;
      end
    end
  end

  // Payload registers without reset.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_acc) frame_q <= in_frame;
    if (state_q == ST_CHECK) begin
      row_q  <= WTAB[pos_q[FRAC_W-1 -: PHASE_W]];
      base_q <= ADDR_W'(ip - POS_INT_W'(TAPS - 1));
    end
    weight_q <= $signed(row_q[tap_q]);
    if (state_q == ST_ROUND) begin
      res_q[prod_q[0]].ch <= merged;
    end
    if (state_q == ST_FINISH && prod_q != 2'd0 && oq_cnt_q == 2'd0) begin
      for (int r = 0; r < 2; r++) begin
        oq_q[r].ch    <= res_q[r].ch;
        oq_q[r].level <= level;
        oq_q[r].last  <= (2'(r) == prod_q - 2'd1);
      end
    end
  end

  assign in_chan.ready = (state_q == ST_IDLE);

  assign out_chan.valid          = (oq_cnt_q != 2'd0);
  assign out_chan.out_ch0        = oq_q[oq_rd_q].ch[0];
  assign out_chan.out_ch1        = oq_q[oq_rd_q].ch[1];
  assign out_chan.out_ch2        = oq_q[oq_rd_q].ch[2];
  assign out_chan.out_ch3        = oq_q[oq_rd_q].ch[3];
  assign out_chan.out_ch4        = oq_q[oq_rd_q].ch[4];
  assign out_chan.out_ch5        = oq_q[oq_rd_q].ch[5];
  assign out_chan.buffered_level = oq_q[oq_rd_q].level;
  assign out_chan.last_of_run    = oq_q[oq_rd_q].last;

endmodule

// ===== src/wsdr_ram.sv =====
module wsdr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/wsdr_lane.sv =====
module wsdr_lane import wsdr_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lane_ctrl_t                 ctrl_i,
  input  logic signed [W_W-1:0]      weight_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  output acc_t                       acc_o
);

  acc_t                              acc_q, acc_d;
  logic signed [W_W+SAMPLE_W-1:0]    prod;

  assign prod = weight_i * sample_i;

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clr) acc_d = '0;
    else if (ctrl_i.en) acc_d = acc_q + ACC_W'(prod);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

// ===== src/wsdr_merge.sv =====
module wsdr_merge import wsdr_pkg::*; (
  input  acc_t   acc_i [CHANNELS],
  input  logic   surround_i,
  output frame_t frame_o
);

  localparam acc_t HALF_LSB = acc_t'(W_ONE / 2);
  localparam acc_t MAX_S    = acc_t'(32767);
  localparam acc_t MIN_S    = -acc_t'(32768);

  always_comb begin
    acc_t y;
    acc_t mag;
    frame_o = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      // Round half away from zero, then clip to the sample range.
      if (acc_i[c] >= 0) begin
        mag = acc_i[c] + HALF_LSB;
        y   = mag >>> 16;
      end else begin
        mag = -acc_i[c] + HALF_LSB;
        y   = -(mag >>> 16);
      end
      if (y > MAX_S) y = MAX_S;
      if (y < MIN_S) y = MIN_S;
      if (surround_i || c < 2) frame_o[c] = y[SAMPLE_W-1:0];
    end
  end

endmodule
